// ----- design/byterun1_plane_decoder_defines.svh -----
// Assertion macros used by the decoder's checker file.
`ifndef BYTERUN1_PLANE_DECODER_DEFINES_SVH
`define BYTERUN1_PLANE_DECODER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define BR1_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define BR1_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/br1_pkg.sv -----
// Shared types, widths and constants of the ByteRun1 plane decoder.
`timescale 1ns / 1ps
`default_nettype none
package br1_pkg;

  localparam int CODE_W = 8;                      // body byte / pixel width
  localparam int ROW_W  = 13;                     // row_bytes and image rows
  localparam int PL_W   = 4;                      // plane_count / plane index
  localparam int TOT_W  = ROW_W + ROW_W + PL_W;   // image byte total
  localparam int RL_W   = ROW_W + 2;              // signed bytes left in row
  localparam int CFG_W  = ROW_W;                  // widest register
  localparam int IDX_W  = 2;

  localparam int DEF_MAX_ROW_BYTES = 4096;
  localparam int DEF_MAX_ROWS      = 4096;
  localparam int DEF_MAX_PLANES    = 8;

  // Header byte codes
  localparam logic [CODE_W-1:0] HDR_NOP = 8'h80;

  // Register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_ROW_BYTES   = 2'd0,
    REG_ROWS        = 2'd1,
    REG_PLANE_COUNT = 2'd2,
    REG_HAS_MASK    = 2'd3
  } reg_idx_t;

  // Decoder phase, one-hot
  typedef enum logic [2:0] {
    PH_HEADER  = 3'b001,
    PH_LITERAL = 3'b010,
    PH_REPEAT  = 3'b100
  } phase_t;

  // Image geometry as seen by the decode core
  typedef struct packed {
    logic [ROW_W-1:0] row_bytes;
    logic [PL_W-1:0]  plane_count;
    logic             has_mask;
    logic [TOT_W-1:0] total;
    logic             restart;      // register written this cycle
    logic [ROW_W-1:0] reload_rows;  // row_bytes value after that write
  } cfg_t;

  // One body byte
  typedef struct packed {
    logic [CODE_W-1:0] code_byte;
    logic              chunk_last;
  } item_t;

  // One decode result
  typedef struct packed {
    logic              emit;
    logic [CODE_W-1:0] pixel_value;
    logic [CODE_W-1:0] repeat_count;
    logic              body_done;
    logic              status;
  } res_t;

endpackage
`default_nettype wire

// ----- design/br1_cfg.sv -----
// Configuration registers and the image size products.
`timescale 1ns / 1ps
`default_nettype none
module br1_cfg #(
  parameter int MAX_ROW_BYTES = br1_pkg::DEF_MAX_ROW_BYTES,
  parameter int MAX_ROWS      = br1_pkg::DEF_MAX_ROWS,
  parameter int MAX_PLANES    = br1_pkg::DEF_MAX_PLANES
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_we,
  input  wire logic [br1_pkg::IDX_W-1:0] cfg_index,
  input  wire logic [br1_pkg::CFG_W-1:0] cfg_wdata,
  output br1_pkg::cfg_t                  cfg
);
  import br1_pkg::*;

  localparam int RR_W = ROW_W + ROW_W;
  localparam int RP_W = ROW_W + PL_W;

  logic [ROW_W-1:0] row_bytes_r, rows_r, rb_sat, rc_sat;
  logic [PL_W-1:0]  plane_count_r, pc_sat;
  logic             has_mask_r;
  logic [RR_W-1:0]  rb_rc_r;   // row_bytes * rows
  logic [RP_W-1:0]  rb_pc_r;   // row_bytes * plane_count
  logic [RP_W-1:0]  rc_pc_r;   // rows * plane_count
  logic [TOT_W-1:0] total_r;
  reg_idx_t         idx;

  assign idx = reg_idx_t'(cfg_index);

  // Saturate written values to the parameter limits
  always_comb begin
    rb_sat = ({{(32-ROW_W){1'b0}}, cfg_wdata} > MAX_ROW_BYTES) ?
             ROW_W'(MAX_ROW_BYTES) : cfg_wdata;
    rc_sat = ({{(32-ROW_W){1'b0}}, cfg_wdata} > MAX_ROWS) ?
             ROW_W'(MAX_ROWS) : cfg_wdata;
    pc_sat = ({{(32-PL_W){1'b0}}, cfg_wdata[PL_W-1:0]} > MAX_PLANES) ?
             PL_W'(MAX_PLANES) : cfg_wdata[PL_W-1:0];
  end

  // Each size write refreshes its two pair products and the total, one multiply each
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_bytes_r   <= ROW_W'(1);
      rows_r        <= ROW_W'(1);
      plane_count_r <= PL_W'(1);
      has_mask_r    <= 1'b0;
      rb_rc_r       <= RR_W'(1);
      rb_pc_r       <= RP_W'(1);
      rc_pc_r       <= RP_W'(1);
      total_r       <= TOT_W'(1);
    end else if (cfg_we) begin
      unique case (idx)
        REG_ROW_BYTES: begin
          row_bytes_r <= rb_sat;
          rb_rc_r     <= RR_W'(rb_sat) * RR_W'(rows_r);
          rb_pc_r     <= RP_W'(rb_sat) * RP_W'(plane_count_r);
          total_r     <= TOT_W'(rb_sat) * TOT_W'(rc_pc_r);
        end
        REG_ROWS: begin
          rows_r  <= rc_sat;
          rb_rc_r <= RR_W'(row_bytes_r) * RR_W'(rc_sat);
          rc_pc_r <= RP_W'(rc_sat) * RP_W'(plane_count_r);
          total_r <= TOT_W'(rb_pc_r) * TOT_W'(rc_sat);
        end
        REG_PLANE_COUNT: begin
          plane_count_r <= pc_sat;
          rb_pc_r       <= RP_W'(row_bytes_r) * RP_W'(pc_sat);
          rc_pc_r       <= RP_W'(rows_r) * RP_W'(pc_sat);
          total_r       <= TOT_W'(rb_rc_r) * TOT_W'(pc_sat);
        end
        REG_HAS_MASK: begin
          has_mask_r <= cfg_wdata[0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cfg.row_bytes   = row_bytes_r;
    cfg.plane_count = plane_count_r;
    cfg.has_mask    = has_mask_r;
    cfg.total       = total_r;
    cfg.restart     = cfg_we;
    cfg.reload_rows = (cfg_we && idx == REG_ROW_BYTES) ? rb_sat : row_bytes_r;
  end

endmodule
`default_nettype wire

// ----- design/br1_core.sv -----
// Decode state and the per-byte run logic.
`timescale 1ns / 1ps
`default_nettype none
module br1_core (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire br1_pkg::cfg_t cfg,
  input  wire logic          fire,
  input  wire br1_pkg::item_t item,
  output br1_pkg::res_t      res
);
  import br1_pkg::*;

  localparam int DF_W = RL_W + 1;
  localparam logic signed [RL_W-1:0] RL_M1 = -RL_W'(1);
  localparam logic signed [RL_W-1:0] RL_M2 = -RL_W'(2);
  localparam logic signed [DF_W-1:0] DF_M1 = -DF_W'(1);

  phase_t                  phase_r, phase_nxt;
  logic [CODE_W-1:0]       lit_left_r, lit_left_nxt;
  logic                    drop_pad_r, drop_pad_nxt;
  logic signed [RL_W-1:0]  row_left_r, row_left_nxt;
  logic [PL_W-1:0]         plane_r, plane_nxt;
  logic [TOT_W-1:0]        written_r, written_nxt;
  logic                    overrun_r, overrun_nxt;

  logic                    mask_row, full, pad;
  logic signed [RL_W-1:0]  row_end, rl_w;
  logic signed [DF_W-1:0]  diff;
  logic [PL_W:0]           pi_inc, pi_lim;
  logic [CODE_W-1:0]       run_n, lit_dec, cnt, val;
  logic [TOT_W-1:0]        room;
  logic                    st;

  always_comb begin
    phase_nxt    = phase_r;
    lit_left_nxt = lit_left_r;
    drop_pad_nxt = drop_pad_r;
    row_left_nxt = row_left_r;
    plane_nxt    = plane_r;
    written_nxt  = written_r;
    overrun_nxt  = overrun_r;
    cnt          = '0;
    val          = '0;
    mask_row     = (plane_r == cfg.plane_count);
    full         = (written_r >= cfg.total);
    room         = cfg.total - written_r;
    row_end      = cfg.row_bytes[0] ? RL_M1 : '0;
    rl_w         = row_left_r;
    pi_inc       = {1'b0, plane_r} + (PL_W+1)'(1);
    pi_lim       = {1'b0, cfg.plane_count} + {{PL_W{1'b0}}, cfg.has_mask};
    lit_dec      = (lit_left_r != '0) ? lit_left_r - CODE_W'(1) : lit_left_r;
    pad          = 1'b0;
    diff         = '0;
    run_n        = '0;

    unique case (phase_r)
      PH_HEADER: begin
        if (!full) begin
          // Row wrap ahead of the header
          if (row_left_r == row_end) begin
            rl_w      = $signed({2'b00, cfg.row_bytes});
            plane_nxt = (pi_inc >= pi_lim) ? '0 : pi_inc[PL_W-1:0];
          end
          if (!item.code_byte[CODE_W-1]) begin
            run_n = {1'b0, item.code_byte[CODE_W-2:0]} + CODE_W'(1);
          end else begin
            run_n = CODE_W'(9'd257 - {1'b0, item.code_byte});
          end
          // Take the run off the row; clamp a row overrun
          diff = $signed({rl_w[RL_W-1], rl_w}) -
                 $signed({{(DF_W-CODE_W){1'b0}}, run_n});
          row_left_nxt = (diff < DF_M1) ? RL_M2 : diff[RL_W-1:0];
          pad = (diff == DF_M1);
          if (!item.code_byte[CODE_W-1]) begin
            lit_left_nxt = run_n;
            drop_pad_nxt = pad;
            phase_nxt    = PH_LITERAL;
          end else if (item.code_byte != HDR_NOP) begin
            lit_left_nxt = pad ? run_n - CODE_W'(1) : run_n;
            phase_nxt    = PH_REPEAT;
          end else begin
            row_left_nxt = rl_w;
          end
        end
      end
      PH_LITERAL: begin
        lit_left_nxt = lit_dec;
        if (!(drop_pad_r && lit_dec == '0) && !mask_row) begin
          if (!full) begin
            cnt         = CODE_W'(1);
            val         = item.code_byte;
            written_nxt = written_r + TOT_W'(1);
          end else begin
            overrun_nxt = 1'b1;
          end
        end
        if (lit_dec == '0) begin
          phase_nxt    = PH_HEADER;
          drop_pad_nxt = 1'b0;
        end
      end
      PH_REPEAT: begin
        if (!mask_row) begin
          if ({{(TOT_W-CODE_W){1'b0}}, lit_left_r} > room) begin
            overrun_nxt = 1'b1;
            cnt         = room[CODE_W-1:0];
          end else begin
            cnt = lit_left_r;
          end
          written_nxt = written_r + {{(TOT_W-CODE_W){1'b0}}, cnt};
          val         = (cnt != '0) ? item.code_byte : '0;
        end
        lit_left_nxt = '0;
        phase_nxt    = PH_HEADER;
      end
      default: begin
        phase_nxt = PH_HEADER;
      end
    endcase

    st = item.chunk_last && (overrun_nxt || written_nxt != cfg.total);

    res.emit         = item.chunk_last || (cnt != '0);
    res.pixel_value  = val;
    res.repeat_count = cnt;
    res.body_done    = item.chunk_last;
    res.status       = st;
  end

  // State update; body end and register writes restart the body
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEADER;
      lit_left_r <= '0;
      drop_pad_r <= 1'b0;
      row_left_r <= RL_W'(1);
      plane_r    <= '0;
      written_r  <= '0;
      overrun_r  <= 1'b0;
    end else if (cfg.restart || (fire && item.chunk_last)) begin
      phase_r    <= PH_HEADER;
      lit_left_r <= '0;
      drop_pad_r <= 1'b0;
      row_left_r <= $signed({2'b00, cfg.restart ? cfg.reload_rows : cfg.row_bytes});
      plane_r    <= '0;
      written_r  <= '0;
      overrun_r  <= 1'b0;
    end else if (fire) begin
      phase_r    <= phase_nxt;
      lit_left_r <= lit_left_nxt;
      drop_pad_r <= drop_pad_nxt;
      row_left_r <= row_left_nxt;
      plane_r    <= plane_nxt;
      written_r  <= written_nxt;
      overrun_r  <= overrun_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- design/byterun1_plane_decoder.sv -----
// Top level of the ByteRun1 plane decoder: input register, core, result register.
//
// Decodes a ByteRun1 (PackBits) image body, one compressed byte per item.
// Input channel: in_tdata carries the body byte, in_tlast marks the chunk's
// last byte. Result channel: out_tdata carries a byte value and a repeat
// count; out_tlast marks the result for the chunk's last byte and out_tuser
// then gives its status (0 ok, 1 corrupt length). A repeat count of 0 is a
// status-only result. A byte that yields no run and is not last gives no result.
// Geometry is set through cfg_we / cfg_index / cfg_wdata while idle; each
// write restarts the body decoder, and the image total is registered by the write.
// A byte is taken into the input register, then decoded into the result
// register once it is free or being emptied. Throughput: one byte per cycle
// while out_tready holds, set by the single decode stage between the registers.
// Reset: geometry 1 x 1 x 1 without mask, decoder waiting for a header.
// Stall: a held result keeps its value; the input register still takes one
// byte, after which in_tready drops until the result is taken.
`timescale 1ns / 1ps
`default_nettype none
module byterun1_plane_decoder #(
  parameter int MAX_ROW_BYTES = br1_pkg::DEF_MAX_ROW_BYTES,
  parameter int MAX_ROWS      = br1_pkg::DEF_MAX_ROWS,
  parameter int MAX_PLANES    = br1_pkg::DEF_MAX_PLANES
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [br1_pkg::IDX_W-1:0]   cfg_index,
  input  wire logic [br1_pkg::CFG_W-1:0]   cfg_wdata,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [br1_pkg::CODE_W-1:0]  in_tdata,   // [7:0] code_byte
  input  wire logic                        in_tlast,   // chunk_last
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic [2*br1_pkg::CODE_W-1:0]     out_tdata,  // [7:0] pixel_value, [15:8] repeat_count
  output logic                             out_tlast,  // body_done
  output logic                             out_tuser   // status
);
  import br1_pkg::*;

  cfg_t  cfg;
  item_t item_r;
  res_t  res, res_r;
  logic  in_vld_r, out_vld_r, fire;

  // Decode happens when the result register is free or being emptied
  assign fire      = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || fire;

  br1_cfg #(
    .MAX_ROW_BYTES (MAX_ROW_BYTES),
    .MAX_ROWS      (MAX_ROWS),
    .MAX_PLANES    (MAX_PLANES)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  br1_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .fire  (fire),
    .item  (item_r),
    .res   (res)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.code_byte  <= in_tdata;
      item_r.chunk_last <= in_tlast;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fire) begin
      out_vld_r <= res.emit;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res.emit) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {res_r.repeat_count, res_r.pixel_value};
  assign out_tlast  = res_r.body_done;
  assign out_tuser  = res_r.status;

endmodule
`default_nettype wire

// ----- design/br1_checker.sv -----
// Port-level checks of the decoder's result channel, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "byterun1_plane_decoder_defines.svh"
module br1_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata,
  input wire logic        out_tlast,
  input wire logic        out_tuser
);

  // A stalled result holds
  `BR1_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser), "result changed while stalled")

  // Only a body end may carry an empty run
  `BR1_ASSERT_NOW(a_empty_only_done, out_tvalid && out_tdata[15:8] == 8'd0, out_tlast, "empty run without body end")

  // A run never exceeds one header's reach
  `BR1_ASSERT_NOW(a_run_max, out_tvalid, out_tdata[15:8] <= 8'd128, "repeat count above 128")

  // Corrupt status only comes with the body end
  `BR1_ASSERT_NOW(a_status_done, out_tvalid && out_tuser, out_tlast, "status without body end")

  // Status-only result carries a zero value
  `BR1_ASSERT_NOW(a_status_zero, out_tvalid && out_tdata[15:8] == 8'd0, out_tdata[7:0] == 8'd0, "nonzero value on status-only result")

endmodule

bind byterun1_plane_decoder br1_checker u_br1_checker (.*);
`default_nettype wire
